// ===== src/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Used by the controller, the datapath and the top level.
package tccw_pkg;

   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int ROW_FW = 5;
   localparam int COL_FW = 7;
   localparam int POS_FW = 11;
   localparam int POS_CALC_W = ROW_FW + COL_FW;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'h80;
   localparam int                TAB_STEP   = 8;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic init_step;
      logic accept;
      logic exec_go;
      logic clear_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scroll;
      logic out_free;
      logic clear_last;
      logic init_last;
   } dp_status_type;

endpackage

// ===== src/tccw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tccw_ctrl.sv =====
// Sequencer for the text console: init sweep, execute, row clear, result load.
// Depends on tccw_pkg.
module tccw_ctrl
   import tccw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.scroll) begin
               state_in = ST_CLEAR;
            end else if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EXEC: begin
            if (sts.scroll) begin
               cmd.exec_go = 1'b1;
            end else if (sts.out_free) begin
               cmd.exec_go  = 1'b1;
               cmd.load_out = 1'b1;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_LOAD: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/tccw_dpath.sv =====
// Datapath: cursor, screen RAM with rotating top row, attribute, result register.
// Depends on tccw_pkg and tccw_ram.
module tccw_dpath
   import tccw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       sts,
   input  logic                req_op,
   input  logic [CHAR_W-1:0]   req_char,
   input  logic [ROW_FW-1:0]   req_row,
   input  logic [COL_FW-1:0]   req_col,
   input  logic                csr_valid,
   input  logic [ATTR_W-1:0]   csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [COL_FW-1:0]   rsp_column,
   output logic [ROW_FW-1:0]   rsp_row,
   output logic [POS_FW-1:0]   rsp_position,
   output logic [CELL_W-1:0]   rsp_cell,
   output logic                rsp_scrolled
);

   localparam int CW = $clog2(SCREEN_COLUMNS);
   localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int AW = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [CW:0]   COLS_X   = (CW+1)'(SCREEN_COLUMNS);
   localparam logic [RW:0]   ROWS_X   = (RW+1)'(SCREEN_ROWS);
   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam int TAB_SH = $clog2(TAB_STEP);

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [RW-1:0]     top_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [CW-1:0]     cnt_col_ff;
   logic [RW-1:0]     cnt_row_ff;
   logic              op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              in_range_ff;
   logic              scroll_ff;
   logic              rsp_valid_ff;
   logic [COL_FW-1:0] rsp_column_ff;
   logic [ROW_FW-1:0] rsp_row_ff;
   logic [POS_FW-1:0] rsp_position_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_scrolled_ff;

   logic [CW:0]       col_x, col_calc, col_tab;
   logic              row_inc, wr_cell, scroll;
   logic [RW:0]       row_x, cur_phys_x, rd_phys_x;
   logic [RW-1:0]     cur_phys, rd_phys;
   logic              rd_range;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;
   logic              init_last, clear_last;
   logic [CW-1:0]     res_col;
   logic [RW-1:0]     res_row;
   logic [POS_CALC_W-1:0] res_pos;

   // cursor update for a put; a read holds the cursor
   always_comb begin
      col_x    = {1'b0, col_ff};
      col_tab  = col_x + (CW+1)'(TAB_STEP);
      col_calc = col_x;
      row_inc  = 1'b0;
      wr_cell  = 1'b0;
      case (char_ff)
         CHAR_BS: begin
            if (col_ff != '0) col_calc = col_x - (CW+1)'(1);
         end
         CHAR_TAB: begin
            col_calc = {col_tab[CW:TAB_SH], {TAB_SH{1'b0}}};
         end
         CHAR_CR: begin
            col_calc = '0;
         end
         CHAR_LF: begin
            col_calc = '0;
            row_inc  = 1'b1;
         end
         default: begin
            if (char_ff >= BLANK_CHAR && char_ff < CHAR_HIGH) begin
               wr_cell  = 1'b1;
               col_calc = col_x + (CW+1)'(1);
            end
         end
      endcase
      if (col_calc >= COLS_X) begin
         col_calc = '0;
         row_inc  = 1'b1;
      end
      row_x  = {1'b0, row_ff} + (RW+1)'(row_inc);
      scroll = 1'b0;
      col_in = col_calc[CW-1:0];
      row_in = row_x[RW-1:0];
      if (row_x >= ROWS_X) begin
         scroll = 1'b1;
         row_in = LAST_ROW;
      end
      if (op_ff == OP_READ) begin
         col_in  = col_ff;
         row_in  = row_ff;
         scroll  = 1'b0;
         wr_cell = 1'b0;
      end
   end

   always_comb begin
      cur_phys_x = {1'b0, row_ff} + {1'b0, top_ff};
      if (cur_phys_x >= ROWS_X) cur_phys_x = cur_phys_x - ROWS_X;
      cur_phys = cur_phys_x[RW-1:0];
      rd_phys_x = {1'b0, req_row[RW-1:0]} + {1'b0, top_ff};
      if (rd_phys_x >= ROWS_X) rd_phys_x = rd_phys_x - ROWS_X;
      rd_phys  = rd_phys_x[RW-1:0];
      rd_range = ({1'b0, req_row} < (ROW_FW+1)'(SCREEN_ROWS)) &&
                 ({1'b0, req_col} < (COL_FW+1)'(SCREEN_COLUMNS));
   end

   assign init_last  = (cnt_col_ff == LAST_COL) && (cnt_row_ff == LAST_ROW);
   assign clear_last = (cnt_col_ff == LAST_COL);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {cur_phys, col_ff};
      ram_wdata = {attr_ff, char_ff};
      if (cmd.init_step) begin
         ram_we    = 1'b1;
         ram_waddr = {cnt_row_ff, cnt_col_ff};
         ram_wdata = {RESET_ATTR, BLANK_CHAR};
      end else if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = {top_ff, cnt_col_ff};
         ram_wdata = {attr_ff, BLANK_CHAR};
      end else if (cmd.exec_go) begin
         ram_we = wr_cell;
      end
   end

   assign ram_re    = cmd.accept && (req_op == OP_READ);
   assign ram_raddr = {rd_phys, req_col[CW-1:0]};

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         top_ff     <= '0;
         attr_ff    <= RESET_ATTR;
         cnt_col_ff <= '0;
         cnt_row_ff <= '0;
      end else begin
         if (csr_valid) attr_ff <= csr_data;
         if (cmd.exec_go) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (cmd.init_step || cmd.clear_step) begin
            if (cnt_col_ff == LAST_COL) begin
               cnt_col_ff <= '0;
               if (cmd.init_step) begin
                  cnt_row_ff <= (cnt_row_ff == LAST_ROW) ? '0 : cnt_row_ff + RW'(1);
               end
            end else begin
               cnt_col_ff <= cnt_col_ff + CW'(1);
            end
         end
         if (cmd.clear_step && clear_last) begin
            top_ff <= (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_op;
         char_ff     <= req_char;
         in_range_ff <= rd_range;
      end
      if (cmd.exec_go) scroll_ff <= scroll;
   end

   // result comes from the fresh cursor in execute, from the registers after a scroll
   always_comb begin
      res_col = cmd.exec_go ? col_in : col_ff;
      res_row = cmd.exec_go ? row_in : row_ff;
      res_pos = POS_CALC_W'(res_row) * POS_CALC_W'(SCREEN_COLUMNS) + POS_CALC_W'(res_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_column_ff   <= COL_FW'(res_col);
         rsp_row_ff      <= ROW_FW'(res_row);
         rsp_position_ff <= res_pos[POS_FW-1:0];
         rsp_cell_ff     <= (op_ff == OP_READ && in_range_ff) ? ram_rdata : '0;
         rsp_scrolled_ff <= cmd.exec_go ? scroll : scroll_ff;
      end
   end

   assign sts.scroll     = scroll;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.clear_last = clear_last;
   assign sts.init_last  = init_last;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_column   = rsp_column_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_cell     = rsp_cell_ff;
   assign rsp_scrolled = rsp_scrolled_ff;

endmodule

// ===== src/text_console_char_writer.sv =====
// Flow: an accepted request beat is executed in ST_EXEC and its result registered;
// a full result register stalls it. The next beat is taken only after the last is done;
// a scroll adds a bottom-row clear through the single RAM write port.
// Reset: synchronous; afterwards an init sweep over every cell blanks the screen RAM
// while req_tready stays low.
module text_console_char_writer
   import tccw_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_code, read_row, read_column, pad
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // cursor_column, cursor_row, cursor_position,
                                   // read_cell, scrolled
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data    // text_attribute
);

   ctrl_cmd_type      cmd;
   dp_status_type     sts;
   logic [COL_FW-1:0] rsp_column;
   logic [ROW_FW-1:0] rsp_row;
   logic [POS_FW-1:0] rsp_position;
   logic [CELL_W-1:0] rsp_cell;
   logic              rsp_scrolled;

   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tccw_dpath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_tuser),
      .req_char     (req_tdata[7:0]),
      .req_row      (req_tdata[12:8]),
      .req_col      (req_tdata[19:13]),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_column   (rsp_column),
      .rsp_row      (rsp_row),
      .rsp_position (rsp_position),
      .rsp_cell     (rsp_cell),
      .rsp_scrolled (rsp_scrolled)
   );

   assign rsp_tdata = {rsp_scrolled, rsp_cell, rsp_position, rsp_row, rsp_column};

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[6:0]} < 8'(SCREEN_COLUMNS)) &&
                     ({1'b0, rsp_tdata[11:7]} < 6'(SCREEN_ROWS)))
      else $error("cursor outside screen");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39]) |-> (rsp_tdata[11:7] == 5'(SCREEN_ROWS - 1)))
      else $error("scrolled result not on last row");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a pending beat");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

endmodule
